### rtl/core/stq_pkg.sv
// shared types and constants for the sorted timeout queue
// no dependencies; imported by every module of the block
package stq_pkg;

    // operation carried from the front to the back
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_GRANT   = 2'd0;
    localparam logic [1:0] KIND_FULL    = 2'd1;
    localparam logic [1:0] KIND_EXPIRED = 2'd2;

    localparam logic [31:0] DEADLINE_CAP = 32'hFFFF_FFFE;

    typedef struct packed {
        logic        op;
        logic [31:0] delay;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic [31:0] deadline;
        logic        last;
    } result_t;

endpackage

### rtl/core/sorted_timeout_queue.sv
// top level of the sorted timeout queue: request front end and queue engine
// depends on stq_pkg, stq_front, stq_engine
//
//  channel   ports                                                 direction
//  request   s_valid s_ready s_func s_delay                        in
//  result    m_valid m_ready m_kind m_slot m_deadline m_last       out
//
// arm: empty or full pool: idle, then output; else a backward walk from the tail
// shifts later deadlines up (one read and one write of the queue memory a cycle)
// tick: an empty queue stays in idle; else timeouts are released from the head in
// order, and the new head is checked again when entries stay queued after a release
// a two-entry request queue lets the front accept while the engine works; the engine
// stalls only while the output register holds an unaccepted result
// reset (aresetn, synchronous) empties the pool and clears the tick count
module sorted_timeout_queue #(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [31:0] s_delay,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_slot,
    output logic [31:0] m_deadline,
    output logic        m_last
);
    import stq_pkg::*;

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_ready;
    result_t res;

    stq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_delay   (s_delay),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    stq_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_kind     = res.kind;
    assign m_slot     = res.slot;
    assign m_deadline = res.deadline;
    assign m_last     = res.last;

endmodule

### rtl/core/stq_front.sv
// front end: takes requests, classifies them and queues them for the engine
// depends on stq_pkg
module stq_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_func,
    input  logic [31:0]   s_delay,
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output stq_pkg::cmd_t cmd
);
    import stq_pkg::*;

    cmd_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;
    cmd_t       in_cmd;

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        in_cmd.op    = s_func ? OP_ARM : OP_TICK;
        in_cmd.delay = s_delay;
        wr_ptr_next  = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = pop ? ~rd_ptr_reg : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

### rtl/core/stq_engine.sv
// back end: sorted deadline queue in a circular buffer memory, arm walk and
// release walk, output register; depends on stq_pkg
module stq_engine #(
    parameter int SLOTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  stq_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output stq_pkg::result_t res
);
    import stq_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = SW + 1;
    localparam int EW = 32 + SW;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_ARM_WALK  = 3'd1;
    localparam logic [2:0] ST_ARM_PUT   = 3'd2;
    localparam logic [2:0] ST_ARM_OUT   = 3'd3;
    localparam logic [2:0] ST_TICK_CHK  = 3'd4;
    localparam logic [2:0] ST_TICK_LAST = 3'd5;

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] p);
        return (p == SW'(SLOTS - 1)) ? '0 : p + SW'(1);
    endfunction

    function automatic logic [SW-1:0] wrap_dec(input logic [SW-1:0] p);
        return (p == '0) ? SW'(SLOTS - 1) : p - SW'(1);
    endfunction

    function automatic logic [3:0] slot_out(input logic [SW-1:0] s);
        logic [SW+3:0] w;
        w = {4'b0000, s};
        return w[3:0];
    endfunction

    // queue storage: position -> {deadline, slot}
    logic [EW-1:0] qmem [SLOTS];
    logic [EW-1:0] rd_data_reg;
    logic          mem_we, mem_re;
    logic [SW-1:0] mem_wa, mem_ra;
    logic [EW-1:0] mem_wd;

    logic [2:0]       state_reg, state_next;
    logic [31:0]      tick_reg, tick_next;
    logic [SW-1:0]    head_reg, head_next;
    logic [SW-1:0]    tail_reg, tail_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [SLOTS-1:0] busy_reg, busy_next;
    logic [SW-1:0]    cur_reg, cur_next;
    logic [SW-1:0]    pos_reg, pos_next;
    logic [31:0]      dl_reg, dl_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic             full_reg, full_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [31:0]      pend_dl_reg, pend_dl_next;
    logic [SW-1:0]    pend_slot_reg, pend_slot_next;
    logic             res_valid_reg;
    result_t          res_reg;

    logic          emit;
    result_t       emit_res;
    logic          out_free;
    logic [SW-1:0] free_slot;
    logic [32:0]   sum;
    logic [31:0]   dl_new;
    logic [31:0]   rd_dl;
    logic [SW-1:0] rd_slot;
    logic          expired;

    assign out_free  = !res_valid_reg || res_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign rd_dl     = rd_data_reg[EW-1:SW];
    assign rd_slot   = rd_data_reg[SW-1:0];
    assign expired   = (tick_reg >= rd_dl);

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_slot = SW'(i);
            end
        end
    end

    always_comb begin
        sum    = {1'b0, tick_reg} + {1'b0, cmd.delay};
        dl_new = (sum > {1'b0, DEADLINE_CAP}) ? DEADLINE_CAP : sum[31:0];
    end

    always_comb begin
        state_next      = state_reg;
        tick_next       = tick_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        len_next        = len_reg;
        busy_next       = busy_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        dl_next         = dl_reg;
        slot_next       = slot_reg;
        full_next       = full_reg;
        pend_valid_next = pend_valid_reg;
        pend_dl_next    = pend_dl_reg;
        pend_slot_next  = pend_slot_reg;
        mem_we          = 1'b0;
        mem_wa          = '0;
        mem_wd          = '0;
        mem_re          = 1'b0;
        mem_ra          = '0;
        emit            = 1'b0;
        emit_res        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.op == OP_ARM) begin
                        dl_next   = dl_new;
                        slot_next = free_slot;
                        full_next = (len_reg == LW'(SLOTS));
                        if (len_reg == LW'(SLOTS)) begin
                            state_next = ST_ARM_OUT;
                        end else if (len_reg == '0) begin
                            mem_we     = 1'b1;
                            mem_wa     = wrap_inc(tail_reg);
                            mem_wd     = {dl_new, free_slot};
                            state_next = ST_ARM_OUT;
                        end else begin
                            // walk back from the tail, shifting later deadlines up
                            mem_re     = 1'b1;
                            mem_ra     = tail_reg;
                            cur_next   = tail_reg;
                            pos_next   = len_reg[SW-1:0] - SW'(1);
                            state_next = ST_ARM_WALK;
                        end
                    end else begin
                        tick_next       = tick_reg + 32'd1;
                        pend_valid_next = 1'b0;
                        if (len_reg != '0) begin
                            mem_re     = 1'b1;
                            mem_ra     = head_reg;
                            state_next = ST_TICK_CHK;
                        end
                    end
                end
            end

            ST_ARM_WALK: begin
                if (rd_dl > dl_reg) begin
                    mem_we = 1'b1;
                    mem_wa = wrap_inc(cur_reg);
                    mem_wd = rd_data_reg;
                    if (pos_reg == '0) begin
                        state_next = ST_ARM_PUT;
                    end else begin
                        mem_re   = 1'b1;
                        mem_ra   = wrap_dec(cur_reg);
                        cur_next = wrap_dec(cur_reg);
                        pos_next = pos_reg - SW'(1);
                    end
                end else begin
                    mem_we     = 1'b1;
                    mem_wa     = wrap_inc(cur_reg);
                    mem_wd     = {dl_reg, slot_reg};
                    state_next = ST_ARM_OUT;
                end
            end

            ST_ARM_PUT: begin
                mem_we     = 1'b1;
                mem_wa     = cur_reg;
                mem_wd     = {dl_reg, slot_reg};
                state_next = ST_ARM_OUT;
            end

            ST_ARM_OUT: begin
                if (out_free) begin
                    emit          = 1'b1;
                    emit_res.last = 1'b1;
                    if (full_reg) begin
                        emit_res.kind = KIND_FULL;
                    end else begin
                        emit_res.kind      = KIND_GRANT;
                        emit_res.slot      = slot_out(slot_reg);
                        emit_res.deadline  = dl_reg;
                        len_next           = len_reg + LW'(1);
                        tail_next          = wrap_inc(tail_reg);
                        busy_next[slot_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_TICK_CHK: begin
                // one release is held back so the final one can carry last
                if (expired) begin
                    if (!pend_valid_reg || out_free) begin
                        if (pend_valid_reg) begin
                            emit              = 1'b1;
                            emit_res.kind     = KIND_EXPIRED;
                            emit_res.slot     = slot_out(pend_slot_reg);
                            emit_res.deadline = pend_dl_reg;
                            emit_res.last     = 1'b0;
                        end
                        pend_valid_next    = 1'b1;
                        pend_dl_next       = rd_dl;
                        pend_slot_next     = rd_slot;
                        busy_next[rd_slot] = 1'b0;
                        head_next          = wrap_inc(head_reg);
                        len_next           = len_reg - LW'(1);
                        if (len_reg != LW'(1)) begin
                            mem_re = 1'b1;
                            mem_ra = wrap_inc(head_reg);
                        end else begin
                            state_next = ST_TICK_LAST;
                        end
                    end
                end else begin
                    state_next = pend_valid_reg ? ST_TICK_LAST : ST_IDLE;
                end
            end

            ST_TICK_LAST: begin
                if (out_free) begin
                    emit              = 1'b1;
                    emit_res.kind     = KIND_EXPIRED;
                    emit_res.slot     = slot_out(pend_slot_reg);
                    emit_res.deadline = pend_dl_reg;
                    emit_res.last     = 1'b1;
                    pend_valid_next   = 1'b0;
                    state_next        = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            tick_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= SW'(SLOTS - 1);
            len_reg        <= '0;
            busy_reg       <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            len_reg        <= len_next;
            busy_reg       <= busy_next;
            pend_valid_reg <= pend_valid_next;
            if (emit) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg       <= cur_next;
        pos_reg       <= pos_next;
        dl_reg        <= dl_next;
        slot_reg      <= slot_next;
        full_reg      <= full_next;
        pend_dl_reg   <= pend_dl_next;
        pend_slot_reg <= pend_slot_next;
        if (emit) begin
            res_reg <= emit_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            qmem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= qmem[mem_ra];
        end
    end

endmodule

### tb/tb_sorted_timeout_queue.sv
// self-checking testbench for the sorted timeout queue: directed and random requests
// checked against an in-bench model of the slot pool and its deadline order
// depends on stq_pkg and sorted_timeout_queue
module tb_sorted_timeout_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import stq_pkg::*;

    localparam int SLOTS = 16;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = OP_TICK;
    logic [31:0] s_delay = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_kind;
    logic [3:0]  m_slot;
    logic [31:0] m_deadline;
    logic        m_last;

    // model of the pool: tick counter, per-slot deadline and busy flag, deadline order
    logic [31:0] pool_tick = '0;
    logic [31:0] pool_deadline [SLOTS];
    logic        pool_busy [SLOTS];
    logic [3:0]  order_slot [SLOTS];
    int unsigned order_len = 0;

    result_t     expected_results [$];
    result_t     want;
    int unsigned mismatch_count = 0;

    bit          tx_idle_on = 1'b1;
    bit          rx_idle_on = 1'b1;
    int unsigned rx_hold_request = 0;
    int unsigned rx_hold_left = 0;
    int unsigned rx_gap_left = 0;
    int unsigned long_arms = 0;

    sorted_timeout_queue #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_delay   (s_delay),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_slot    (m_slot),
        .m_deadline(m_deadline),
        .m_last    (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            pool_busy[i] = 1'b0;
            pool_deadline[i] = '0;
            order_slot[i] = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0h wanted %0h", $realtime, what, got, exp_val);
    endtask

    // work out the results of one accepted request and queue them
    task automatic predict_request(input logic func, input logic [31:0] delay);
        int          free_slot;
        int unsigned pos;
        int unsigned i;
        int unsigned n;
        logic [32:0] sum;
        logic [31:0] dl;
        logic [3:0]  s;
        result_t     batch [SLOTS];
        free_slot = -1;
        n = 0;
        if (func == OP_ARM) begin
            for (i = SLOTS; i > 0; i--) begin
                if (!pool_busy[i - 1]) free_slot = i - 1;
            end
            if (free_slot < 0) begin
                expected_results.push_back('{kind: KIND_FULL, slot: 4'd0,
                                             deadline: 32'd0, last: 1'b1});
            end else begin
                sum = {1'b0, pool_tick} + {1'b0, delay};
                dl = (sum > {1'b0, DEADLINE_CAP}) ? DEADLINE_CAP : sum[31:0];
                // goes behind every entry with an equal or earlier deadline
                pos = 0;
                while (pos < order_len && pool_deadline[order_slot[pos]] <= dl) pos++;
                for (i = order_len; i > pos; i--) order_slot[i] = order_slot[i - 1];
                order_slot[pos] = 4'(free_slot);
                order_len++;
                pool_busy[free_slot] = 1'b1;
                pool_deadline[free_slot] = dl;
                expected_results.push_back('{kind: KIND_GRANT, slot: 4'(free_slot),
                                             deadline: dl, last: 1'b1});
            end
        end else begin
            pool_tick = pool_tick + 32'd1;
            while (order_len > 0 && pool_deadline[order_slot[0]] <= pool_tick) begin
                s = order_slot[0];
                for (i = 0; i + 1 < order_len; i++) order_slot[i] = order_slot[i + 1];
                order_len--;
                pool_busy[s] = 1'b0;
                batch[n] = '{kind: KIND_EXPIRED, slot: s, deadline: pool_deadline[s],
                             last: 1'b0};
                n++;
            end
            if (n > 0) batch[n - 1].last = 1'b1;
            for (i = 0; i < n; i++) expected_results.push_back(batch[i]);
        end
    endtask

    // offer one request, hold it until accepted, then update the model
    task automatic send_request(input logic func, input logic [31:0] delay);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= func;
        s_delay <= delay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(func, delay);
    endtask

    // sender stops until every queued result has come back
    task automatic wait_results_drained();
        int unsigned waited;
        waited = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0 && waited < 20000) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            report_mismatch("results never arrived, count", expected_results.size(), 0);
            expected_results.delete();
        end
    endtask

    // result side: random stall bursts plus an occasional long hold-off
    always @(posedge aclk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_ready <= 1'b0;
        end else if (rx_hold_request != 0) begin
            rx_hold_left <= rx_hold_request - 1;
            rx_hold_request = 0;
            m_ready <= 1'b0;
        end else if (rx_gap_left > 0) begin
            rx_gap_left <= rx_gap_left - 1;
            m_ready <= 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap_left <= $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, slot", 32'(m_slot), 0);
            end else begin
                want = expected_results.pop_front();
                if (m_kind !== want.kind) begin
                    report_mismatch("kind", 32'(m_kind), 32'(want.kind));
                end
                if (m_slot !== want.slot) begin
                    report_mismatch("slot", 32'(m_slot), 32'(want.slot));
                end
                if (m_deadline !== want.deadline) begin
                    report_mismatch("deadline", m_deadline, want.deadline);
                end
                if (m_last !== want.last) begin
                    report_mismatch("last", 32'(m_last), 32'(want.last));
                end
            end
        end
    end

    task automatic test_empty_tick();
        send_request(OP_TICK, 32'd0);
        send_request(OP_TICK, 32'hFFFF_FFFF);
    endtask

    // zero delay expires on the very next tick
    task automatic test_zero_delay();
        send_request(OP_ARM, 32'd0);
        send_request(OP_ARM, 32'd0);
        send_request(OP_TICK, 32'd0);
    endtask

    // all slots on one deadline, one refused, then one tick releases them all in slot order
    task automatic test_full_pool_release();
        repeat (SLOTS) send_request(OP_ARM, 32'd1);
        send_request(OP_ARM, 32'd3);
        send_request(OP_TICK, 32'd0);
    endtask

    // these two never expire and keep their slots for the rest of the run
    task automatic test_deadline_cap();
        send_request(OP_ARM, 32'hFFFF_FFFF);
        send_request(OP_ARM, DEADLINE_CAP - pool_tick);
        long_arms = 2;
    endtask

    task automatic test_random_traffic(input int unsigned count);
        int unsigned pick;
        logic [31:0] delay;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                send_request(OP_TICK, $urandom);
            end else begin
                if (pick < 47 && long_arms < 4) begin
                    delay = {1'b1, 31'($urandom)};
                    long_arms++;
                end else if (pick < 80) begin
                    delay = $urandom_range(0, 6);
                end else begin
                    delay = $urandom_range(0, 30);
                end
                send_request(OP_ARM, delay);
            end
        end
    endtask

    // receiver holds off while requests keep coming, so the input side must stall
    task automatic test_receiver_hold();
        tx_idle_on = 1'b0;
        rx_hold_request = 300;
        test_random_traffic(40);
        wait_results_drained();
        tx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_tick();
        test_zero_delay();
        test_full_pool_release();
        test_deadline_cap();
        test_random_traffic(150);
        test_receiver_hold();
        test_random_traffic(150);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_traffic(60);
        wait_results_drained();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
